>>> design/cbe_pkg.sv
// Shared types, widths and constants for the cubic Bezier point evaluator.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package cbe_pkg;

    localparam int COORD_W      = 16;   // control point and world coordinate width
    localparam int ZOOM_W       = 9;
    localparam int TFIELD_W     = 17;   // width of the curve_t field
    localparam int OUT_W        = 19;
    localparam int MAX_POINTS   = 4;
    localparam int AXES         = 2;
    localparam int PT_IDX_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int PERCENT      = 100;

    localparam int NUM_POINTS_DEF  = 4;
    localparam int T_FRAC_BITS_DEF = 16;

    // Floor division by PERCENT: q = (m * DIV_RECIP) >> DIV_SHIFT.
    // DIV_RECIP = ceil(2^32 / 100); exact for every magnitude below 2^29.
    localparam int DIV_SHIFT  = 32;
    localparam int DIV_RECIP_W = 26;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 26'd42949673;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [OUT_W-1:0]   t_screen;

    typedef struct packed {
        logic [ZOOM_W-1:0] zoom;
        t_coord            pan_x;
        t_coord            pan_y;
    } t_view;

    function automatic t_coord ctrl_reset(input logic axis, input logic [PT_IDX_W-1:0] pt);
        t_coord v;
        unique case ({axis, pt})
            3'b000:  v = 16'sd60;
            3'b001:  v = 16'sd180;
            3'b010:  v = 16'sd420;
            3'b011:  v = 16'sd540;
            3'b100:  v = 16'sd200;
            3'b101:  v = 16'sd80;
            3'b110:  v = 16'sd320;
            3'b111:  v = 16'sd200;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/cbe_in_if.sv
// Input channel of the Bezier evaluator: parameter t plus view zoom and pan.
// Depends on cbe_pkg for field widths.
`default_nettype none

interface cbe_in_if;
    logic                            valid;
    logic                            ready;
    logic [cbe_pkg::TFIELD_W-1:0]    curve_t;
    logic [cbe_pkg::ZOOM_W-1:0]      zoom_percent;
    logic signed [cbe_pkg::COORD_W-1:0] pan_x;
    logic signed [cbe_pkg::COORD_W-1:0] pan_y;

    modport source (output valid, curve_t, zoom_percent, pan_x, pan_y, input ready);
    modport sink   (input valid, curve_t, zoom_percent, pan_x, pan_y, output ready);
endinterface

`default_nettype wire

>>> design/cbe_out_if.sv
// Output channel of the Bezier evaluator: screen coordinates of one curve point.
// Depends on cbe_pkg for field widths.
`default_nettype none

interface cbe_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [cbe_pkg::OUT_W-1:0] screen_x;
    logic signed [cbe_pkg::OUT_W-1:0] screen_y;

    modport source (output valid, screen_x, screen_y, input ready);
    modport sink   (input valid, screen_x, screen_y, output ready);
endinterface

`default_nettype wire

>>> design/cbe_level.sv
// One De Casteljau level: multiply stage, then add and truncate-toward-zero stage.
// Depends on cbe_pkg; instantiated NUM_POINTS-1 times by the top level.
`default_nettype none

module cbe_level #(
    parameter int P      = cbe_pkg::NUM_POINTS_DEF,
    parameter int TF     = cbe_pkg::T_FRAC_BITS_DEF,
    parameter int ACTIVE = P - 1
) (
    input  wire logic          i_clk,
    input  wire logic [1:0]    i_en,
    input  wire logic [TF:0]   i_t,
    input  wire cbe_pkg::t_view  i_view,
    input  wire cbe_pkg::t_coord i_pts [cbe_pkg::AXES][P],
    output logic [TF:0]        o_t,
    output cbe_pkg::t_view     o_view,
    output cbe_pkg::t_coord    o_pts [cbe_pkg::AXES][P]
);

    localparam int CW    = cbe_pkg::COORD_W;
    localparam int DIFF_W = CW + 1;
    localparam int PRD_W = DIFF_W + TF + 2;
    localparam int NUM_W = PRD_W + 1;

    logic [TF:0]    r_t0, r_t1;
    cbe_pkg::t_view r_view0, r_view1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t0    <= i_t;
            r_view0 <= i_view;
        end
        if (i_en[1]) begin
            r_t1    <= r_t0;
            r_view1 <= r_view0;
        end
    end

    assign o_t    = r_t1;
    assign o_view = r_view1;

    for (genvar a = 0; a < cbe_pkg::AXES; a++) begin : g_axis
        for (genvar m = 0; m < P; m++) begin : g_lane
            if (m < ACTIVE) begin : g_on
                logic signed [DIFF_W-1:0] w_diff;
                logic signed [TF+1:0]     w_ts;
                logic signed [PRD_W-1:0]  r_prod;
                cbe_pkg::t_coord          r_a;
                cbe_pkg::t_coord          r_res;
                logic signed [NUM_W-1:0]  w_num;
                logic signed [NUM_W-1:0]  w_bias;
                logic signed [NUM_W-1:0]  w_rnd;

                assign w_diff = DIFF_W'(i_pts[a][m+1]) - DIFF_W'(i_pts[a][m]);
                assign w_ts   = {1'b0, i_t};

                always_ff @(posedge i_clk) begin
                    if (i_en[0]) begin
                        r_prod <= w_diff * w_ts;
                        r_a    <= i_pts[a][m];
                    end
                    if (i_en[1]) begin
                        r_res <= w_rnd[TF+CW-1:TF];
                    end
                end

                // a*2^F + t*(b-a), biased by 2^F-1 when negative so the shift truncates
                assign w_num  = {{(NUM_W-CW-TF){r_a[CW-1]}}, r_a, {TF{1'b0}}}
                              + {{(NUM_W-PRD_W){r_prod[PRD_W-1]}}, r_prod};
                assign w_bias = {{(NUM_W-TF){1'b0}}, {TF{w_num[NUM_W-1]}}};
                assign w_rnd  = w_num + w_bias;
                assign o_pts[a][m] = r_res;
            end else begin : g_off
                assign o_pts[a][m] = '0;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/cbe_screen.sv
// Screen mapping: trunc((w*zoom + pan*100) / 100) in four register stages,
// the division done as a reciprocal multiply on the magnitude. Depends on cbe_pkg.
`default_nettype none

module cbe_screen (
    input  wire logic        i_clk,
    input  wire logic [3:0]  i_en,
    input  wire cbe_pkg::t_coord i_w [cbe_pkg::AXES],
    input  wire cbe_pkg::t_view  i_view,
    output cbe_pkg::t_screen o_screen [cbe_pkg::AXES]
);

    localparam int CW    = cbe_pkg::COORD_W;
    localparam int SCL_W = CW + cbe_pkg::ZOOM_W + 1;
    localparam int PAN_W = CW + 8;
    localparam int SUM_W = SCL_W + 1;
    localparam int MAG_W = SCL_W;
    localparam int QF_W  = MAG_W + cbe_pkg::DIV_RECIP_W;
    localparam int OW    = cbe_pkg::OUT_W;
    localparam logic signed [PAN_W-1:0] PCT = PAN_W'(cbe_pkg::PERCENT);

    logic signed [cbe_pkg::ZOOM_W:0] w_zoom;
    assign w_zoom = {1'b0, i_view.zoom};

    for (genvar a = 0; a < cbe_pkg::AXES; a++) begin : g_axis
        cbe_pkg::t_coord          w_pan;
        logic signed [SCL_W-1:0]  r_scl;
        logic signed [PAN_W-1:0]  r_pan;
        logic signed [SUM_W-1:0]  w_sum;
        logic [MAG_W-1:0]         r_mag;
        logic                     r_neg1, r_neg2;
        logic [QF_W-1:0]          r_qf;
        logic [OW-1:0]            w_q;
        cbe_pkg::t_screen         r_out;

        if (a == cbe_pkg::AXIS_X) begin : g_px
            assign w_pan = i_view.pan_x;
        end else begin : g_py
            assign w_pan = i_view.pan_y;
        end

        assign w_sum = SUM_W'(r_scl) + SUM_W'(r_pan);
        assign w_q   = r_qf[cbe_pkg::DIV_SHIFT+OW-1:cbe_pkg::DIV_SHIFT];

        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_scl <= i_w[a] * w_zoom;
                r_pan <= w_pan * PCT;
            end
            if (i_en[1]) begin
                r_neg1 <= w_sum[SUM_W-1];
                r_mag  <= w_sum[SUM_W-1] ? MAG_W'(-w_sum) : MAG_W'(w_sum);
            end
            if (i_en[2]) begin
                r_neg2 <= r_neg1;
                r_qf   <= QF_W'(r_mag) * QF_W'(cbe_pkg::DIV_RECIP);
            end
            if (i_en[3]) begin
                r_out <= r_neg2 ? -w_q : w_q;
            end
        end

        assign o_screen[a] = r_out;
    end

endmodule

`default_nettype wire

>>> design/cubic_bezier_point_eval_core.sv
// Top level of the cubic Bezier point evaluator: control point registers,
// t saturation, De Casteljau level chain and screen mapping. Depends on cbe_pkg,
// cbe_in_if, cbe_out_if, cbe_level and cbe_screen.
//
//  channel   dir   handshake        payload
//  i_pt      in    valid / ready    curve_t, zoom_percent, pan_x, pan_y
//  o_pt      out   valid / ready    screen_x, screen_y
//  i_cfg_*   in    i_cfg_we only    i_cfg_idx, i_cfg_data
//
// One point per cycle sustained while o_pt.ready is high; two stages per De
// Casteljau level (multiply, add/truncate) and four for the zoom, pan and
// reciprocal-multiply divide by 100.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up under a stall and input is taken while a result waits.
// Synchronous active-low reset clears the stage valid bits and loads the
// default control points.
`default_nettype none

module cubic_bezier_point_eval_core #(
    parameter int NUM_POINTS  = cbe_pkg::NUM_POINTS_DEF,
    parameter int T_FRAC_BITS = cbe_pkg::T_FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    cbe_in_if.sink                               i_pt,
    cbe_out_if.source                            o_pt,
    input  wire logic                            i_cfg_we,
    input  wire logic [cbe_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cbe_pkg::COORD_W-1:0]     i_cfg_data
);

    localparam int TF    = T_FRAC_BITS;
    localparam int NS    = 2 * (NUM_POINTS - 1) + 4;
    localparam int CMP_W = (cbe_pkg::TFIELD_W > TF + 2) ? cbe_pkg::TFIELD_W : TF + 2;
    localparam logic [CMP_W-1:0] T_ONE = CMP_W'(1) << TF;

    // control points, [axis][point]
    cbe_pkg::t_coord r_ctrl [cbe_pkg::AXES][cbe_pkg::MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < cbe_pkg::AXES; a++) begin
                for (int p = 0; p < cbe_pkg::MAX_POINTS; p++) begin
                    r_ctrl[a][p] <= cbe_pkg::ctrl_reset(1'(a), cbe_pkg::PT_IDX_W'(p));
                end
            end
        end else if (i_cfg_we) begin
            r_ctrl[i_cfg_idx[0]][i_cfg_idx[cbe_pkg::CFG_IDX_W-1:1]] <= i_cfg_data;
        end
    end

    // stage valid bits and the advance chain
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_adv;

    always_comb begin
        w_adv[NS] = o_pt.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_pt.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_pt.ready = w_adv[0];
    assign o_pt.valid = r_vld[NS-1];

    // t above one clamps to one
    logic [CMP_W-1:0] w_t_ext;
    logic [TF:0]      w_t_sat;

    assign w_t_ext = CMP_W'(i_pt.curve_t);
    assign w_t_sat = (w_t_ext > T_ONE) ? T_ONE[TF:0] : w_t_ext[TF:0];

    // level chain: index l holds the points entering level l
    cbe_pkg::t_coord w_pts  [NUM_POINTS][cbe_pkg::AXES][NUM_POINTS];
    logic [TF:0]     w_t    [NUM_POINTS];
    cbe_pkg::t_view  w_view [NUM_POINTS];

    assign w_t[0]    = w_t_sat;
    assign w_view[0] = '{zoom: i_pt.zoom_percent, pan_x: i_pt.pan_x, pan_y: i_pt.pan_y};

    for (genvar a = 0; a < cbe_pkg::AXES; a++) begin : g_ctrl_axis
        for (genvar p = 0; p < NUM_POINTS; p++) begin : g_ctrl_pt
            assign w_pts[0][a][p] = r_ctrl[a][p];
        end
    end

    for (genvar l = 0; l < NUM_POINTS - 1; l++) begin : g_level
        cbe_level #(
            .P      (NUM_POINTS),
            .TF     (TF),
            .ACTIVE (NUM_POINTS - 1 - l)
        ) u_level (
            .i_clk  (i_clk),
            .i_en   (w_adv[2*l+1:2*l]),
            .i_t    (w_t[l]),
            .i_view (w_view[l]),
            .i_pts  (w_pts[l]),
            .o_t    (w_t[l+1]),
            .o_view (w_view[l+1]),
            .o_pts  (w_pts[l+1])
        );
    end

    cbe_pkg::t_coord  w_world  [cbe_pkg::AXES];
    cbe_pkg::t_screen w_screen [cbe_pkg::AXES];

    assign w_world[cbe_pkg::AXIS_X] = w_pts[NUM_POINTS-1][cbe_pkg::AXIS_X][0];
    assign w_world[cbe_pkg::AXIS_Y] = w_pts[NUM_POINTS-1][cbe_pkg::AXIS_Y][0];

    cbe_screen u_screen (
        .i_clk    (i_clk),
        .i_en     (w_adv[NS-1:NS-4]),
        .i_w      (w_world),
        .i_view   (w_view[NUM_POINTS-1]),
        .o_screen (w_screen)
    );

    assign o_pt.screen_x = w_screen[cbe_pkg::AXIS_X];
    assign o_pt.screen_y = w_screen[cbe_pkg::AXIS_Y];

endmodule

`default_nettype wire

>>> design/cbe_checker.sv
// Port-level assertions for cubic_bezier_point_eval_core, attached by bind.
// Depends on cbe_pkg for widths.
`default_nettype none

module cbe_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [cbe_pkg::OUT_W-1:0]    i_screen_x,
    input wire logic [cbe_pkg::OUT_W-1:0]    i_screen_y
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // an empty output stage means every stage can advance
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output stage is empty");

    // a stalled transaction keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // and its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_screen_x) && $stable(i_screen_y))
        else $error("output payload changed while stalled");

endmodule

bind cubic_bezier_point_eval_core cbe_checker u_cbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_screen_x  (o_pt.screen_x),
    .i_screen_y  (o_pt.screen_y)
);

`default_nettype wire
